>>> hdl/rgb_to_hsi_pixel_top_defines.svh
// ----------------------------------------------------------------------------
// RGB to HSI pixel converter: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSI_PIXEL_TOP_DEFINES_SVH
`define RGB_TO_HSI_PIXEL_TOP_DEFINES_SVH

// Same-cycle implication.
`define RHP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define RHP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/rgbhsi_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSI pixel converter: package
// Pipeline stage record and the hue boundary cosine tables.
// ----------------------------------------------------------------------------
package rgbhsi_pkg;

  localparam int NumStages = 9;
  localparam longint OneQ30 = 64'sd1073741824;
  localparam longint CosStepQ30 = 64'sd1073415892;

  typedef logic signed [17:0] cos_tab_t [128];
  typedef logic [35:0] csq_tab_t [128];

  typedef struct packed {
    logic        xneg;
    logic [17:0] xsq;
    logic [15:0] den;
    logic        bh;
    logic        gray;
    logic [6:0]  k;
    logic        zero_sum;
    logic [9:0]  sum;
    logic [17:0] rem;
    logic [7:0]  quo;
    logic [7:0]  inten;
  } stage_t;

  // Round p / 2^sh half away from zero.
  function automatic longint round_shift(longint p, int sh);
    longint mag;
    longint q;
    mag = (p < 0) ? -p : p;
    q = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
    return (p < 0) ? -q : q;
  endfunction

  // Boundary cosines cos(m*360/255 deg) with 16 fraction bits.
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t t;
    longint prev;
    longint cur;
    longint nxt;
    prev = OneQ30;
    cur = CosStepQ30;
    t[0] = 18'sd65536;
    for (int m = 1; m < 128; m++) begin
      t[m] = 18'(round_shift(cur, 14));
      nxt = round_shift(2 * CosStepQ30 * cur, 30) - prev;
      prev = cur;
      cur = nxt;
    end
    return t;
  endfunction

  localparam cos_tab_t CosTab = build_cos_tab();

  // Four times the square of each boundary cosine.
  function automatic csq_tab_t build_csq_tab();
    csq_tab_t s;
    longint c;
    for (int m = 0; m < 128; m++) begin
      c = longint'(CosTab[m]);
      s[m] = 36'(4 * c * c);
    end
    return s;
  endfunction

  localparam csq_tab_t CsqTab = build_csq_tab();

endpackage

>>> hdl/rgb_to_hsi_pixel_top.sv
// ----------------------------------------------------------------------------
// RGB to HSI pixel converter
// Converts one 8-bit blue/green/red pixel to hue, saturation and intensity.
// ----------------------------------------------------------------------------
// channel | handshake                 | payload
// in      | in_valid_i / in_ready_o   | blue_i, green_i, red_i
// out     | out_valid_o / out_ready_i | hue_o, saturation_o, intensity_o
//
// Nine register stages; a result is offered from the last stage, and one item can
// enter per cycle unless a stall fills the front stage. The front stage forms the
// differences, squares and sums; the eight following stages each take one
// saturation quotient bit, and the first seven of them one hue search bit too.
// Reset clears all stage valid bits; payload registers are not reset.
// A stall holds each full stage and lets empty stages ahead of it fill.
// ----------------------------------------------------------------------------
`include "rgb_to_hsi_pixel_top_defines.svh"

module rgb_to_hsi_pixel_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] blue_i,
  input  logic [7:0] green_i,
  input  logic [7:0] red_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] hue_o,
  output logic [7:0] saturation_o,
  output logic [7:0] intensity_o
);

  localparam int N = rgbhsi_pkg::NumStages;

  rgbhsi_pkg::stage_t pipe_q [N];
  logic [N-1:0]       valid_q;
  logic [N:0]         rdy;
  rgbhsi_pkg::stage_t front_d;

  assign rdy[N] = out_ready_i;
  for (genvar i = 0; i < N; i++) begin : g_rdy
    assign rdy[i] = !valid_q[i] || rdy[i+1];
  end
  assign in_ready_o = rdy[0];

  // Front stage arithmetic.
  logic [9:0]         sum;
  logic [7:0]         mn;
  logic signed [8:0]  dr_g;
  logic signed [8:0]  dr_b;
  logic signed [8:0]  dg_b;
  logic signed [9:0]  x;
  logic [8:0]         xmag;
  logic signed [17:0] den_s;
  logic [9:0]         spread;
  logic [18:0]        third;

  always_comb begin
    sum = 10'(blue_i) + 10'(green_i) + 10'(red_i);
    mn = blue_i;
    if (green_i < mn) mn = green_i;
    if (red_i < mn) mn = red_i;
    dr_g = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    dr_b = $signed({1'b0, red_i}) - $signed({1'b0, blue_i});
    dg_b = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    x = 10'(dr_g) + 10'(dr_b);
    xmag = x[9] ? 9'(-x) : 9'(x);
    // Half the sum of the three squared differences, never negative.
    den_s = 18'(dr_g * dr_g) + 18'(dr_b * dg_b);
    spread = sum - 10'(3 * {2'b0, mn});
    third = 19'(sum) * 19'd683;
    front_d.xneg = x[9];
    front_d.xsq = 18'(xmag) * 18'(xmag);
    front_d.den = den_s[15:0];
    front_d.bh = blue_i > green_i;
    front_d.gray = (den_s == 18'sd0);
    front_d.k = '0;
    front_d.zero_sum = (sum == 10'd0);
    front_d.sum = sum;
    front_d.rem = {spread, 8'b0} - 18'(spread);
    front_d.quo = '0;
    front_d.inten = third[18:11];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      valid_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy[0]) begin
      pipe_q[0] <= front_d;
    end
  end

  // Stage i resolves quotient bit 8-i and, for i up to 7, hue search bit 7-i.
  for (genvar i = 1; i < N; i++) begin : g_stage
    rgbhsi_pkg::stage_t nxt_d;
    logic [17:0] trial;
    logic [6:0]  m;
    logic [51:0] lhs;
    logic [51:0] rhs;
    logic        cneg;
    logic        gt;
    logic        lt;
    logic        s_pos;
    logic        s_neg;
    logic        take;

    always_comb begin
      nxt_d = pipe_q[i-1];
      trial = 18'(pipe_q[i-1].sum) << (8 - i);
      if (pipe_q[i-1].rem >= trial) begin
        nxt_d.rem = pipe_q[i-1].rem - trial;
        nxt_d.quo[8-i] = 1'b1;
      end
      m = pipe_q[i-1].k | 7'(1 << (i < 8 ? 7 - i : 0));
      lhs = {2'b0, pipe_q[i-1].xsq, 32'b0};
      rhs = 52'(rgbhsi_pkg::CsqTab[m]) * 52'(pipe_q[i-1].den);
      cneg = rgbhsi_pkg::CosTab[m][17];
      gt = lhs > rhs;
      lt = lhs < rhs;
      // Sign of x*2^16 - 2*C*sqrt(den).
      s_pos = (!pipe_q[i-1].xneg && cneg) || (!pipe_q[i-1].xneg && !cneg && gt)
              || (pipe_q[i-1].xneg && cneg && lt);
      s_neg = (pipe_q[i-1].xneg && !cneg) || (!pipe_q[i-1].xneg && !cneg && lt)
              || (pipe_q[i-1].xneg && cneg && gt);
      take = pipe_q[i-1].bh ? s_neg : !s_pos;
      if (i < 8 && take) begin
        nxt_d.k = m;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        valid_q[i] <= valid_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (valid_q[i-1] && rdy[i]) begin
        pipe_q[i] <= nxt_d;
      end
    end
  end

  assign out_valid_o = valid_q[N-1];
  assign hue_o = pipe_q[N-1].gray ? 8'd0
               : (pipe_q[N-1].bh ? 8'd254 - 8'(pipe_q[N-1].k) : 8'(pipe_q[N-1].k));
  assign saturation_o = pipe_q[N-1].zero_sum ? 8'd0 : pipe_q[N-1].quo;
  assign intensity_o = pipe_q[N-1].inten;

  `RHP_ASSERT_NEXT(a_accept_fills, in_valid_i && in_ready_o, valid_q[0])
  `RHP_ASSERT_IMPL(a_full_front, !in_ready_o, valid_q[0])
  `RHP_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(pipe_q[N-1]))
  `RHP_ASSERT_IMPL(a_rem_bound, out_valid_o && !pipe_q[N-1].zero_sum,
                   pipe_q[N-1].rem < 18'(pipe_q[N-1].sum))

endmodule
